>>> rtl/core/fiq_pkg.sv
// Package for the feedback input qualifier.
// Holds the sizes, register indexes, lane control struct and the on-mask helper.
// No dependencies.
package fiq_pkg;

    // Sizes of the pin array and of the transaction fields.
    localparam int NUM_PORTS     = 3;
    localparam int PINS_PER_PORT = 8;
    localparam int PORT_W        = 2;
    localparam int SAMPLE_W      = 8;
    localparam int HIST_W        = 8;
    localparam int CNT_W         = 8;
    localparam int CFG_W         = 8;
    localparam int CFG_IDX_W     = 1;
    localparam int PORT_IDX_W    = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ON_SAMPLES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_DELAY      = 1'b1;

    // Control shared by every lane for one transaction.
    typedef struct packed {
        logic                  update;
        logic [PORT_IDX_W-1:0] port;
        logic [HIST_W-1:0]     on_mask;
        logic [CNT_W-1:0]      off_delay;
    } lane_ctrl_t;

    // Mask of the last N history bits, with N clamped to 1..HIST_W.
    function automatic logic [HIST_W-1:0] on_mask(input logic [CFG_W-1:0] min_on);
        logic [CFG_W-1:0]  n;
        logic [HIST_W:0]   ones;
        n = min_on;
        if (n == '0)
        begin
            n = CFG_W'(1);
        end
        if (n > CFG_W'(HIST_W))
        begin
            n = CFG_W'(HIST_W);
        end
        ones = ((HIST_W+1)'(1) << n) - (HIST_W+1)'(1);
        return ones[HIST_W-1:0];
    endfunction

endpackage

>>> rtl/core/feedback_input_qualifier.sv
// Top level of the feedback input qualifier: configuration, pin lanes and merge.
// Depends on fiq_pkg, fiq_lane and fiq_merge.
//
//   Channel   Direction  Handshake               Payload
//   input     in         in_valid / in_stall     port_index, raw_sample
//   result    out        out_valid / out_stall   port_echo, qualified_flags
//   config    in         cfg_we                  cfg_index, cfg_data
//
// One transaction is accepted per cycle while in_stall is low; its result is
// loaded into the output register in the next cycle. The rate is set by the
// per-pin read-modify-write of lane state, done by all eight lanes in parallel.
// Reset clears all pin state and loads min_on_samples = 1, off_delay = 0.
// A stalled result holds the output register; input is stalled only while a
// result waits and the result side stalls.
module feedback_input_qualifier (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [fiq_pkg::PORT_W-1:0]       port_index,
    input  logic [fiq_pkg::SAMPLE_W-1:0]     raw_sample,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [fiq_pkg::PORT_W-1:0]       port_echo,
    output logic [fiq_pkg::SAMPLE_W-1:0]     qualified_flags,
    input  logic                             cfg_we,
    input  logic [fiq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fiq_pkg::CFG_W-1:0]        cfg_data
);
    import fiq_pkg::*;

    logic [HIST_W-1:0]        on_mask_reg;
    logic [CNT_W-1:0]         off_delay_reg;
    logic                     accept;
    logic                     in_range;
    lane_ctrl_t               ctrl;
    logic [PINS_PER_PORT-1:0] lane_flags;

    // Configuration registers; the on-mask is kept already decoded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_mask_reg   <= on_mask(CFG_W'(1));
            off_delay_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_ON_SAMPLES: on_mask_reg   <= on_mask(cfg_data);
                CFG_OFF_DELAY:      off_delay_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Input handshake and lane control.
    assign in_stall = out_valid && out_stall;
    assign accept   = in_valid && !in_stall;
    assign in_range = (32'(port_index) < NUM_PORTS);

    always_comb
    begin
        ctrl.update    = accept && in_range;
        ctrl.port      = PORT_IDX_W'(port_index);
        ctrl.on_mask   = on_mask_reg;
        ctrl.off_delay = off_delay_reg;
    end

    // One lane per pin of a port.
    for (genvar j = 0; j < PINS_PER_PORT; j++)
    begin : g_lane
        fiq_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .sample_bit (raw_sample[j]),
            .flag       (lane_flags[j])
        );
    end

    // Merge the lane flags into the result register.
    fiq_merge u_merge (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .in_range        (in_range),
        .port            (port_index),
        .lane_flags      (lane_flags),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .port_echo       (port_echo),
        .qualified_flags (qualified_flags)
    );

endmodule

>>> rtl/core/fiq_lane.sv
// One pin lane of the feedback input qualifier.
// Keeps history, off-delay counter and qualified flag of this pin in every port.
// Depends on fiq_pkg.
module fiq_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  fiq_pkg::lane_ctrl_t ctrl,
    input  logic                sample_bit,
    output logic                flag
);
    import fiq_pkg::*;

    logic [HIST_W-1:0] hist_reg [NUM_PORTS];
    logic [CNT_W-1:0]  cnt_reg  [NUM_PORTS];
    logic [NUM_PORTS-1:0] qual_reg;

    logic [HIST_W-1:0] hist_next;
    logic [CNT_W-1:0]  cnt_next;
    logic              qual_next;
    logic [CNT_W-1:0]  cnt_cur;

    // Update of the selected port: history first, then counter, then flag.
    always_comb
    begin
        cnt_cur   = cnt_reg[ctrl.port];
        hist_next = {hist_reg[ctrl.port][HIST_W-2:0], sample_bit};
        if (sample_bit)
        begin
            cnt_next = ctrl.off_delay;
        end
        else if (cnt_cur != '0)
        begin
            cnt_next = cnt_cur - CNT_W'(1);
        end
        else
        begin
            cnt_next = '0;
        end
        if (qual_reg[ctrl.port])
        begin
            qual_next = (cnt_next != '0);
        end
        else
        begin
            qual_next = ((hist_next & ctrl.on_mask) == ctrl.on_mask);
        end
    end

    assign flag = qual_next;

    // Per-port state storage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PORTS; p++)
            begin
                hist_reg[p] <= '0;
                cnt_reg[p]  <= '0;
            end
            qual_reg <= '0;
        end
        else if (ctrl.update)
        begin
            hist_reg[ctrl.port] <= hist_next;
            cnt_reg[ctrl.port]  <= cnt_next;
            qual_reg[ctrl.port] <= qual_next;
        end
    end

endmodule

>>> rtl/core/fiq_merge.sv
// Merging stage of the feedback input qualifier.
// Collects the lane flags into the output register that feeds the result channel.
// Depends on fiq_pkg.
module fiq_merge (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  logic                                 in_range,
    input  logic [fiq_pkg::PORT_W-1:0]           port,
    input  logic [fiq_pkg::PINS_PER_PORT-1:0]    lane_flags,
    input  logic                                 out_stall,
    output logic                                 out_valid,
    output logic [fiq_pkg::PORT_W-1:0]           port_echo,
    output logic [fiq_pkg::SAMPLE_W-1:0]         qualified_flags
);
    import fiq_pkg::*;

    logic                valid_reg;
    logic                valid_next;
    logic [PORT_W-1:0]   port_reg;
    logic [SAMPLE_W-1:0] flags_reg;
    logic [SAMPLE_W-1:0] flags_next;

    // Out-of-range ports report no flags; unused pin positions stay zero.
    always_comb
    begin
        flags_next = in_range ? SAMPLE_W'(lane_flags) : '0;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // Valid flag of the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result payload, loaded with each accepted transaction.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            port_reg  <= port;
            flags_reg <= flags_next;
        end
    end

    assign out_valid       = valid_reg;
    assign port_echo       = port_reg;
    assign qualified_flags = flags_reg;

endmodule
